// File: rtl/apdtrk_pkg.sv
package apdtrk_pkg;

   // Cell memory geometry.
   localparam int CELL_CNT = 4096;
   localparam int ADDR_W   = $clog2(CELL_CNT);

   // Field widths.
   localparam int IDX_W   = 12;
   localparam int TIME_W  = 32;
   localparam int VOLT_W  = 16;
   localparam int COUNT_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 64;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ACT_THRESHOLD   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPOL_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRACTORY_GAP  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_TIME      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP       = 3'd4;

   // Reset values of the registers (Q8.8 mV for voltages, 1/100 ms ticks for times).
   localparam logic signed [VOLT_W-1:0] ACT_THRESHOLD_RST   = -16'sd7680;
   localparam logic signed [VOLT_W-1:0] REPOL_THRESHOLD_RST = -16'sd21248;
   localparam logic [TIME_W-1:0]        REFRACTORY_GAP_RST  = 32'd1000;
   localparam logic [TIME_W-1:0]        FINAL_TIME_RST      = 32'd0;
   localparam logic [TIME_W-1:0]        TIME_STEP_RST       = 32'd2;

   // Resting voltage of a cell after reset, -100 mV.
   localparam logic signed [VOLT_W-1:0] RESET_VOLTAGE = -16'sd25600;
   localparam logic [COUNT_W-1:0]       COUNT_MAX     = {COUNT_W{1'b1}};

   // One entry of the per-cell memory.
   typedef struct packed {
      logic signed [VOLT_W-1:0] prev_volt;
      logic [TIME_W-1:0]        latest_act;
      logic                     has_activated;
      logic                     apd_pending;
      logic [COUNT_W-1:0]       act_count;
   } cell_state_type;

   localparam int STATE_W = $bits(cell_state_type);

   localparam cell_state_type CELL_STATE_RST = '{
      prev_volt:     RESET_VOLTAGE,
      latest_act:    '0,
      has_activated: 1'b0,
      apd_pending:   1'b0,
      act_count:     '0
   };

   // Thresholds and the refractory gap shared by the update logic.
   typedef struct packed {
      logic signed [VOLT_W-1:0] act_threshold;
      logic signed [VOLT_W-1:0] repol_threshold;
      logic [TIME_W-1:0]        refractory_gap;
   } cfg_type;

   // One sample as it sits in the update stage.
   typedef struct packed {
      logic [IDX_W-1:0]         cell_index;
      logic                     cell_active;
      logic [TIME_W-1:0]        sample_time;
      logic signed [VOLT_W-1:0] voltage;
      logic                     last_step;
   } sample_type;

   // One result.
   typedef struct packed {
      logic [IDX_W-1:0]   cell_id;
      logic               activation_event;
      logic [COUNT_W-1:0] activation_total;
      logic               apd_valid;
      logic [TIME_W-1:0]  apd_value;
   } result_type;

endpackage

// File: rtl/apdtrk_ram.sv
module apdtrk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read and a write to the same address in one cycle return the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/apdtrk_update.sv
module apdtrk_update (
   input  apdtrk_pkg::cfg_type        cfg,
   input  apdtrk_pkg::sample_type     sample,
   input  apdtrk_pkg::cell_state_type state_cur,
   output apdtrk_pkg::cell_state_type state_new,
   output logic                       state_we,
   output apdtrk_pkg::result_type     result
);
   import apdtrk_pkg::*;

   logic              in_range;
   logic              live;
   logic              time_zero;
   logic [TIME_W:0]   since;
   logic              past_gap;
   logic              crossing;
   logic              act_event;
   logic              open_two;
   logic              open_any;
   logic              close_apd;
   logic [COUNT_W-1:0] count_new;

   always_comb begin
      in_range  = {1'b0, sample.cell_index} < (IDX_W + 1)'(CELL_CNT);
      live      = in_range && sample.cell_active;
      time_zero = (sample.sample_time == '0);

      // Signed distance from the last activation; negative never passes the gap.
      since    = {1'b0, sample.sample_time} - {1'b0, state_cur.latest_act};
      past_gap = !since[TIME_W] && (since[TIME_W-1:0] > cfg.refractory_gap);
      crossing = (state_cur.prev_volt < cfg.act_threshold) &&
                 (sample.voltage >= cfg.act_threshold);
      act_event = live && !time_zero && crossing &&
                  (!state_cur.has_activated || past_gap);

      open_two  = act_event && state_cur.apd_pending;
      open_any  = act_event || state_cur.apd_pending;
      close_apd = live && !time_zero && open_any &&
                  ((sample.voltage <= cfg.repol_threshold) || open_two ||
                   sample.last_step);

      count_new = state_cur.act_count;
      if (act_event && (state_cur.act_count != COUNT_MAX)) begin
         count_new = state_cur.act_count + COUNT_W'(1);
      end

      state_we  = live;
      state_new = state_cur;
      state_new.prev_volt = sample.voltage;
      if (!time_zero) begin
         state_new.act_count   = count_new;
         state_new.apd_pending = open_any && !(close_apd && !open_two);
         if (act_event) begin
            state_new.latest_act    = sample.sample_time;
            state_new.has_activated = 1'b1;
         end
      end

      result.cell_id          = sample.cell_index;
      result.activation_event = act_event;
      result.activation_total = in_range ? count_new : '0;
      result.apd_valid        = close_apd;
      // A fresh activation closed in the same sample has zero duration;
      // otherwise the duration runs from the stored activation.
      if (close_apd && !(act_event && !state_cur.apd_pending)) begin
         result.apd_value = since[TIME_W-1:0];
      end else begin
         result.apd_value = '0;
      end
   end

endmodule

// File: rtl/activation_time_and_apd_tracker_unit.sv
// Channel     | Ports                         | Content
// ------------+-------------------------------+------------------------------------------
// request in  | req_tvalid/tready/tdata       | one voltage sample of one cell
// response out| rsp_tvalid/tready/tdata       | one result per sample
// config      | csr_we, csr_index, csr_wdata  | threshold and time registers, write only
//
// A request is held in the update stage register and then in the output
// register, where its result is offered; a new request is accepted every cycle
// while the response side takes results. After reset the cell memory is swept
// to its rest values, one entry a cycle, over all 4096 entries, and no request
// is accepted before the sweep ends. A stalled response holds the update stage,
// and through it the request side.
//
// The per-cell state lives in one memory with a registered read. A request reads
// its entry as it is accepted; the update stage computes the new entry and
// writes it back as the result moves on. The request read in that same cycle
// gets the old word, so the written word is kept and forwarded to it when the
// two requests name the same cell.
module activation_time_and_apd_tracker_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata, lowest bit up: cell_index[11:0], cell_active[12],
   // sample_time[44:13], voltage[60:45], zero fill[63:61]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [apdtrk_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata, lowest bit up: cell_id[11:0], activation_event[12],
   // activation_total[28:13], apd_valid[29], apd_value[61:30], zero fill[63:62]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [apdtrk_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                  csr_we,
   input  logic [apdtrk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [apdtrk_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import apdtrk_pkg::*;

   // Configuration registers.
   logic signed [VOLT_W-1:0] act_thr_ff;
   logic signed [VOLT_W-1:0] repol_thr_ff;
   logic [TIME_W-1:0]        gap_ff;
   logic [TIME_W-1:0]        final_time_ff;
   logic [TIME_W-1:0]        time_step_ff;

   // Memory sweep after reset.
   logic              clr_active_ff;
   logic [ADDR_W-1:0] clr_addr_ff;

   // Update stage.
   logic           s1_valid_ff;
   sample_type     s1_sample_ff;
   logic           fwd_hit_ff;
   cell_state_type fwd_data_ff;

   // Output register.
   logic       rsp_valid_ff;
   result_type rsp_data_ff;

   sample_type     req_sample;
   logic [TIME_W:0] time_left;
   logic           req_accept;
   logic           s1_move;
   logic           out_free;
   cfg_type        cfg;
   cell_state_type ram_rd_state;
   cell_state_type state_cur;
   cell_state_type state_new;
   logic           state_we;
   result_type     result;
   logic           ram_we;
   logic [ADDR_W-1:0] ram_wr_addr;
   cell_state_type ram_wr_data;
   logic [STATE_W-1:0] ram_rd_data;

   // Request unpacking; the last-step test depends only on the request and
   // the registers, so it is settled before the memory word arrives.
   always_comb begin
      req_sample.cell_index  = req_tdata[11:0];
      req_sample.cell_active = req_tdata[12];
      req_sample.sample_time = req_tdata[44:13];
      req_sample.voltage     = req_tdata[60:45];
      time_left = {1'b0, final_time_ff} - {1'b0, req_tdata[44:13]};
      req_sample.last_step = time_left[TIME_W] ||
                             (time_left[TIME_W-1:0] <= time_step_ff);
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !clr_active_ff && (!s1_valid_ff || out_free);
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_thr_ff    <= ACT_THRESHOLD_RST;
         repol_thr_ff  <= REPOL_THRESHOLD_RST;
         gap_ff        <= REFRACTORY_GAP_RST;
         final_time_ff <= FINAL_TIME_RST;
         time_step_ff  <= TIME_STEP_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACT_THRESHOLD:   act_thr_ff    <= csr_wdata[VOLT_W-1:0];
            CSR_REPOL_THRESHOLD: repol_thr_ff  <= csr_wdata[VOLT_W-1:0];
            CSR_REFRACTORY_GAP:  gap_ff        <= csr_wdata;
            CSR_FINAL_TIME:      final_time_ff <= csr_wdata;
            CSR_TIME_STEP:       time_step_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == ADDR_W'(CELL_CNT - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   // Memory write port: the sweep after reset, then the update stage.
   always_comb begin
      if (clr_active_ff) begin
         ram_we      = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = CELL_STATE_RST;
      end else begin
         ram_we      = s1_move && state_we;
         ram_wr_addr = s1_sample_ff.cell_index[ADDR_W-1:0];
         ram_wr_data = state_new;
      end
   end

   apdtrk_ram #(
      .WIDTH (STATE_W),
      .DEPTH (CELL_CNT)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_sample.cell_index[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_state = cell_state_type'(ram_rd_data);
   assign state_cur    = fwd_hit_ff ? fwd_data_ff : ram_rd_state;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // The word written in the cycle a request reads its entry is forwarded when it names the same cell.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_sample;
         fwd_hit_ff   <= ram_we &&
                         (ram_wr_addr == req_sample.cell_index[ADDR_W-1:0]);
         fwd_data_ff  <= ram_wr_data;
      end
   end

   assign cfg.act_threshold   = act_thr_ff;
   assign cfg.repol_threshold = repol_thr_ff;
   assign cfg.refractory_gap  = gap_ff;

   apdtrk_update u_update (
      .cfg       (cfg),
      .sample    (s1_sample_ff),
      .state_cur (state_cur),
      .state_new (state_new),
      .state_we  (state_we),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        rsp_data_ff.apd_value,
                        rsp_data_ff.apd_valid,
                        rsp_data_ff.activation_total,
                        rsp_data_ff.activation_event,
                        rsp_data_ff.cell_id};

endmodule
